FILE: rtl/speed_command_line_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the speed command line parser
// ---------------------------------------------------------------------------
`ifndef SPEED_COMMAND_LINE_PARSER_MACROS_SVH
`define SPEED_COMMAND_LINE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scl assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define SCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scl assertion failed");

`endif

FILE: rtl/scl_pkg.sv
// ---------------------------------------------------------------------------
// scl_pkg
// Shared constants, types and the prefix table of the command line parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scl_pkg;

  // Line buffer size; a line holds at most LINE_BUFFER_BYTES-1 bytes
  localparam int LINE_BUFFER_BYTES = 32;
  localparam int COUNT_W           = $clog2(LINE_BUFFER_BYTES);

  localparam int PREFIX_LEN = 7;
  localparam int PREFIX_W   = 3;

  localparam int SPEED_W = 32;
  // Product of a saturated magnitude and ten, plus a digit
  localparam int PROD_W  = SPEED_W + 4;

  // Character codes
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Saturation limits of the magnitude
  localparam logic [PROD_W-1:0] LIMIT_POS = PROD_W'(64'd2147483647);
  localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(64'd2147483648);

  // Matcher phases, one-hot
  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

  // One result item
  typedef struct packed {
    logic               command_ok;
    logic [SPEED_W-1:0] speed_value;
  } result_t;

  // Parser to result register
  typedef struct packed {
    logic    ends_line;
    result_t res;
  } parse_out_t;

  // "@speed%"
  function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h40;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h70;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h65;
      3'd5:    ch = 8'h64;
      3'd6:    ch = 8'h25;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/scl_parser.sv
// ---------------------------------------------------------------------------
// scl_parser
// Line state and the per-byte matcher: one byte is taken per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speed_command_line_parser_macros.svh"

module scl_parser
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output parse_out_t parse_out
);

  logic [COUNT_W-1:0]  count_r, count_nxt;
  phase_t              phase_r, phase_nxt;
  logic [PREFIX_W-1:0] pos_r, pos_nxt;
  logic                neg_r, neg_nxt;
  logic                dig_r, dig_nxt;
  logic [SPEED_W-1:0]  acc_r, acc_nxt;

  logic               is_at, is_end, is_digit, is_blank;
  logic [PROD_W-1:0]  prod, limit;
  logic [SPEED_W-1:0] acc_dig;

  assign is_at    = (rx_byte == CH_AT);
  assign is_end   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);

  // acc*10 + digit, clamped to the sign's limit
  assign prod  = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1) + PROD_W'(rx_byte[3:0]);
  assign limit = neg_r ? LIMIT_NEG : LIMIT_POS;
  assign acc_dig = (prod > limit) ? limit[SPEED_W-1:0] : prod[SPEED_W-1:0];

  // Result of the current line
  always_comb begin
    parse_out.ends_line       = is_end;
    parse_out.res.command_ok  = dig_r;
    parse_out.res.speed_value = '0;
    if (dig_r) begin
      parse_out.res.speed_value = neg_r ? (SPEED_W'(0) - acc_r) : acc_r;
    end
  end

  // Next line state
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    if (is_at) begin
      // restart; the '@' is the first prefix byte
      count_nxt = COUNT_W'(1);
      phase_nxt = PH_PREFIX;
      pos_nxt   = PREFIX_W'(1);
      neg_nxt   = 1'b0;
      dig_nxt   = 1'b0;
      acc_nxt   = '0;
    end else if (is_end) begin
      count_nxt = '0;
      phase_nxt = PH_PREFIX;
      pos_nxt   = '0;
      neg_nxt   = 1'b0;
      dig_nxt   = 1'b0;
      acc_nxt   = '0;
    end else if (count_r < COUNT_W'(LINE_BUFFER_BYTES - 1)) begin
      count_nxt = count_r + COUNT_W'(1);
      unique case (phase_r) inside
        PH_PREFIX: begin
          if ((pos_r < PREFIX_W'(PREFIX_LEN)) && (rx_byte == prefix_char(pos_r))) begin
            pos_nxt = pos_r + PREFIX_W'(1);
            if (pos_r == PREFIX_W'(PREFIX_LEN - 1)) begin
              phase_nxt = PH_SPACE;
            end
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_SPACE: begin
          if (is_blank) begin
            phase_nxt = PH_SPACE;
          end else if (rx_byte == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGNED;
          end else if (rx_byte == CH_PLUS) begin
            phase_nxt = PH_SIGNED;
          end else if (is_digit) begin
            acc_nxt   = acc_dig;
            dig_nxt   = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_SIGNED: begin
          if (is_digit) begin
            acc_nxt   = acc_dig;
            dig_nxt   = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_nxt = acc_dig;
            dig_nxt = 1'b1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE, PH_FAIL: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= PH_PREFIX;
      pos_r   <= '0;
      neg_r   <= 1'b0;
      dig_r   <= 1'b0;
      acc_r   <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      neg_r   <= neg_nxt;
      dig_r   <= dig_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Checks
  `SCL_ASSERT_IMP(a_digit_phase, dig_r,
                  (phase_r == PH_DIGITS) || (phase_r == PH_DONE))
  `SCL_ASSERT_IMP(a_acc_limit, !neg_r, acc_r <= LIMIT_POS[SPEED_W-1:0])
  `SCL_ASSERT_IMP(a_prefix_pos, phase_r == PH_PREFIX, pos_r < PREFIX_W'(PREFIX_LEN))

endmodule

FILE: rtl/scl_result_reg.sv
// ---------------------------------------------------------------------------
// scl_result_reg
// Output register of the result channel with valid/stall handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scl_result_reg
  import scl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  result_t            res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_command_ok,
  output logic [SPEED_W-1:0] out_speed_value
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  // Room for a new item when empty or the held item leaves this cycle
  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = vld_r;
  assign out_command_ok  = res_r.command_ok;
  assign out_speed_value = res_r.speed_value;

endmodule

FILE: rtl/speed_command_line_parser.sv
// ---------------------------------------------------------------------------
// speed_command_line_parser
// Gathers serial bytes into command lines and emits parsed speed commands.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_rx_byte) takes one received byte
//   per item. Result channel (out_valid, out_stall, out_command_ok,
//   out_speed_value) gives one item for each CR or LF byte, none otherwise.
//   Path: a line-end byte goes through the input register, then the result
//   register; its result is loaded as the byte leaves the input register.
//   Throughput: one byte per cycle while in_stall is low; the line state is
//   updated when the byte leaves the input register.
//   Stall: a full result register stalled by the receiver holds its item;
//   bytes that give no result keep flowing, and a line-end byte waits in the
//   input register, which then raises in_stall.
//   Reset (rst_n low, synchronous): both registers empty, line state
//   cleared to the start of prefix matching.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speed_command_line_parser_macros.svh"

module speed_command_line_parser
  import scl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_command_ok,
  output logic [SPEED_W-1:0] out_speed_value
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_take, step_go, out_free;
  parse_out_t parse_out;

  // The held byte moves on unless it needs the result register and that is full and stalled
  assign step_go  = in_vld_r && (!parse_out.ends_line || out_free);
  assign in_stall = in_vld_r && !step_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (step_go) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  scl_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_go),
    .rx_byte   (in_byte_r),
    .parse_out (parse_out)
  );

  scl_result_reg u_result (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step_go && parse_out.ends_line),
    .res             (parse_out.res),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command_ok  (out_command_ok),
    .out_speed_value (out_speed_value)
  );

  // Checks
  `SCL_ASSERT_IMP(a_stall_needs_item, in_stall, in_vld_r && parse_out.ends_line)
  `SCL_ASSERT_IMP(a_load_has_room, step_go && parse_out.ends_line, out_free)
  `SCL_ASSERT_IMP(a_bad_is_zero, out_valid && !out_command_ok, out_speed_value == '0)

endmodule
